[hw/rtl/rgb24_to_yuv420_converter_core_defines.svh]
// Assertion macros for the RGB24 to YUV 4:2:0 converter.
`ifndef RGB24_TO_YUV420_CONVERTER_CORE_DEFINES_SVH
`define RGB24_TO_YUV420_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RGB2YUV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb2yuv: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RGB2YUV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb2yuv: next-cycle check failed");

`endif

[hw/rtl/rgb2yuv_pkg.sv]
// Shared types and constants of the RGB24 to YUV 4:2:0 converter.
`timescale 1ns / 1ps

package rgb2yuv_pkg;

	localparam int PIX_W        = 8;
	localparam int CFG_W        = 13;
	localparam int DEF_MAX_SIDE = 4096;

	localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

	// BT.601 integer coefficients
	localparam int Y_R = 66;
	localparam int Y_G = 129;
	localparam int Y_B = 25;
	localparam int U_R = 38;
	localparam int U_G = 74;
	localparam int U_B = 112;
	localparam int V_R = 112;
	localparam int V_G = 94;
	localparam int V_B = 18;
	localparam int ROUND_OFS  = 128;
	localparam int LUMA_OFS   = 16;
	localparam int CHROMA_OFS = 32768;

	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	// Position flags of one pixel, taken when the pixel is accepted
	typedef struct packed {
		logic col_even;
		logic row_odd;
		logic frame_end;
	} pos_info_t;

endpackage

[hw/rtl/rgb2yuv_pos.sv]
// Frame size registers and column/row tracker of the converter.
`timescale 1ns / 1ps

module rgb2yuv_pos
	import rgb2yuv_pkg::*;
#(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             advance,
	output pos_info_t        info
);

	localparam int POS_W  = $clog2(MAX_SIDE);
	localparam int SIZE_W = (CFG_W > POS_W + 1) ? CFG_W : POS_W + 1;

	logic [CFG_W-1:0]  width_q, height_q;
	logic [POS_W-1:0]  col_q, row_q;
	logic [SIZE_W-1:0] width_eff, height_eff;
	logic [SIZE_W-1:0] col_inc, row_inc;
	logic              row_wrap, frame_wrap;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
		logic [SIZE_W-1:0] ext;
		ext = SIZE_W'(v);
		if (ext == '0)
			return SIZE_W'(1);
		else if (ext > SIZE_W'(MAX_SIDE))
			return SIZE_W'(MAX_SIDE);
		else
			return ext;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		width_eff  = eff_size(width_q);
		height_eff = eff_size(height_q);
		col_inc    = SIZE_W'(col_q) + SIZE_W'(1);
		row_inc    = SIZE_W'(row_q) + SIZE_W'(1);
		row_wrap   = (col_inc >= width_eff);
		frame_wrap = row_wrap && (row_inc >= height_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= row_wrap ? '0 : col_inc[POS_W-1:0];
			if (row_wrap)
				row_q <= frame_wrap ? '0 : row_inc[POS_W-1:0];
		end
	end

	assign info.col_even  = ~col_q[0];
	assign info.row_odd   = row_q[0];
	assign info.frame_end = frame_wrap;

endmodule

[hw/rtl/rgb2yuv_csc.sv]
// BT.601 color space arithmetic: luma for every pixel and one chroma sample on even columns.
`timescale 1ns / 1ps

module rgb2yuv_csc
	import rgb2yuv_pkg::*;
(
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,
	input  pos_info_t        info,
	output logic [PIX_W-1:0] luma,
	output logic             chroma_valid,
	output logic             chroma_kind,
	output logic [PIX_W-1:0] chroma
);

	logic [15:0]        r_u, g_u, b_u, y_sum;
	logic signed [16:0] r_s, g_s, b_s, u_sum, v_sum, c_biased;

	always_comb begin
		r_u = 16'(red);
		g_u = 16'(green);
		b_u = 16'(blue);
		y_sum = r_u * 16'(Y_R) + g_u * 16'(Y_G) + b_u * 16'(Y_B) + 16'(ROUND_OFS);
		luma  = y_sum[15:8] + 8'(LUMA_OFS);

		r_s = $signed(17'(red));
		g_s = $signed(17'(green));
		b_s = $signed(17'(blue));
		u_sum = b_s * $signed(17'(U_B)) - r_s * $signed(17'(U_R))
			- g_s * $signed(17'(U_G)) + $signed(17'(ROUND_OFS));
		v_sum = r_s * $signed(17'(V_R)) - g_s * $signed(17'(V_G))
			- b_s * $signed(17'(V_B)) + $signed(17'(ROUND_OFS));

		// floor shift plus 128, wrapped to a byte
		c_biased = (info.row_odd ? v_sum : u_sum) + $signed(17'(CHROMA_OFS));

		chroma_valid = info.col_even;
		chroma_kind  = info.col_even & info.row_odd;
		chroma       = info.col_even ? c_biased[15:8] : '0;
	end

endmodule

[hw/rtl/rgb24_to_yuv420_converter_core.sv]
// Top level of the RGB24 to YUV 4:2:0 pixel converter.
`timescale 1ns / 1ps

// RGB24 to YUV 4:2:0 converter (BT.601, studio range). Send one RGB24 pixel
// per request on the input channel in raster order; every request returns
// one result on the output channel: the Y sample, plus on even columns one
// chroma sample taken from that pixel alone (U on even rows, V on odd rows,
// no averaging). frame_end marks the last pixel of each frame. The block
// sustains one pixel per clock unless out_ready holds it back: a pixel is
// captured into an input register and the color arithmetic runs between
// that register and the result register. Both stages hold under
// backpressure and accept a new request whenever the stage ahead moves.
// Program frame_width and frame_height (index 0 and 1) only while the
// block is idle; a size of 0 acts as 1 and a size above MAX_SIDE acts as
// MAX_SIDE. Reset gives a 640 x 480 frame starting at column 0, row 0.
module rgb24_to_yuv420_converter_core
	import rgb2yuv_pkg::*;
#(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// pixel input
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,
	// result output
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] luma,
	output logic             chroma_valid,
	output logic             chroma_kind,
	output logic [PIX_W-1:0] chroma,
	output logic             frame_end
);

	`include "rgb24_to_yuv420_converter_core_defines.svh"

	logic             in_fire, s1_adv, out_free;
	pos_info_t        pos_info;

	// input stage
	logic             valid_s1;
	logic [PIX_W-1:0] red_s1, green_s1, blue_s1;
	pos_info_t        info_s1;

	// result stage
	logic [PIX_W-1:0] luma_c, chroma_c;
	logic             cvalid_c, ckind_c;
	logic [PIX_W-1:0] luma_s2, chroma_s2;
	logic             cvalid_s2, ckind_s2, fend_s2;

	// The result register frees up when empty or when its request is taken.
	assign out_free = !out_valid || out_ready;
	assign s1_adv   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_fire  = in_valid && in_ready;

	// Position advances on every accepted pixel; flags ride along with it.
	rgb2yuv_pos #(
		.MAX_SIDE (MAX_SIDE)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_fire),
		.info      (pos_info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	// Capture the pixel and its position flags.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			info_s1  <= pos_info;
		end
	end

	rgb2yuv_csc u_csc (
		.red          (red_s1),
		.green        (green_s1),
		.blue         (blue_s1),
		.info         (info_s1),
		.luma         (luma_c),
		.chroma_valid (cvalid_c),
		.chroma_kind  (ckind_c),
		.chroma       (chroma_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_free)
			out_valid <= valid_s1;
	end

	// Hold the result until the consumer takes it.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			luma_s2   <= luma_c;
			chroma_s2 <= chroma_c;
			cvalid_s2 <= cvalid_c;
			ckind_s2  <= ckind_c;
			fend_s2   <= info_s1.frame_end;
		end
	end

	assign luma         = luma_s2;
	assign chroma       = chroma_s2;
	assign chroma_valid = cvalid_s2;
	assign chroma_kind  = ckind_s2;
	assign frame_end    = fend_s2;

	// Odd-column results carry no chroma at all.
	`RGB2YUV_ASSERT_NOW(a_no_chroma_odd_col, out_valid && !chroma_valid, chroma == '0 && !chroma_kind)
	// A pending input stage always moves into an empty result register.
	`RGB2YUV_ASSERT_NEXT(a_s1_drains, valid_s1 && !out_valid, out_valid)
	// An empty input stage never blocks the input.
	`RGB2YUV_ASSERT_NOW(a_ready_when_empty, !valid_s1, in_ready)

endmodule
